/* design/vrq_pkg.sv */
// Shared widths, types and constants for the quaternion vector rotation block.
`timescale 1ns / 1ps

package vrq_pkg;

  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int VEC_WIDTH_DEF      = 16;

  // Fixed field widths
  localparam int QUAT_W   = 16;
  localparam int VEC_IN_W = 16;
  localparam int OUT_W    = 18;

  // Vector after extension: one bit above the port covers the zero-extended case
  localparam int VEXT_W = VEC_IN_W + 1;
  // Square/cross products of two quaternion parts
  localparam int PP_W   = 2 * QUAT_W;
  // Rotation matrix entries reach about +-2^32
  localparam int COEF_W = PP_W + 2;
  localparam int PROD_W = COEF_W + VEXT_W;

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [VEXT_W-1:0] vext_t;
  typedef logic signed [PP_W-1:0]   pp_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [OUT_W-1:0]  res_t;

  // Load enables for the row pipeline stages
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

endpackage

/* design/vrq_row.sv */
// One row of the rotation: three products, sum, round to nearest and saturate.
`timescale 1ns / 1ps

module vrq_row #(
  parameter int QUAT_FRAC_BITS = vrq_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  vrq_pkg::stage_en_t  en,
  input  vrq_pkg::coef_t      c0,
  input  vrq_pkg::coef_t      c1,
  input  vrq_pkg::coef_t      c2,
  input  vrq_pkg::vext_t      v0,
  input  vrq_pkg::vext_t      v1,
  input  vrq_pkg::vext_t      v2,
  output vrq_pkg::res_t       res,
  output logic                sat
);

  import vrq_pkg::*;

  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  localparam int ACC_W = (SHIFT + 20 > PROD_W + 2) ? SHIFT + 20 : PROD_W + 2;

  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

  logic signed [PROD_W-1:0] m0, m1, m2;
  logic signed [ACC_W-1:0]  sum_a, sum_b, acc;
  logic signed [ACC_W-1:0]  scaled;

  assign scaled = acc >>> SHIFT;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      m0 <= c0 * v0;
      m1 <= c1 * v1;
      m2 <= c2 * v2;
    end
    if (en.s4) begin
      sum_a <= ACC_W'(m0) + ACC_W'(m1);
      sum_b <= ACC_W'(m2) + HALF;
    end
    if (en.s5) begin
      acc <= sum_a + sum_b;
    end
    if (en.s6) begin
      if (scaled > SAT_HI) begin
        res <= OUT_W'(OUT_MAX);
        sat <= 1'b1;
      end else if (scaled < SAT_LO) begin
        res <= OUT_W'(OUT_MIN);
        sat <= 1'b1;
      end else begin
        res <= scaled[OUT_W-1:0];
        sat <= 1'b0;
      end
    end
  end

endmodule

/* design/vector_rotate_by_quaternion.sv */
// Top level: pipelined rotation of a 3D vector by a fixed-point quaternion.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready) carries one beat per rotation: the
//   quaternion quat_w..quat_z (signed, QUAT_FRAC_BITS fraction bits) and the
//   vector vec_x..vec_z (signed integers, sign-extended from VEC_WIDTH bits).
//   Output channel (out_valid/out_ready) returns one beat per input beat:
//   out_x..out_z, rounded to nearest (ties upward) and clipped to 18 bits,
//   plus saturated when any component was clipped.
//   The quaternion is used as given; an unnormalized q scales by |q|^2.
// Timing
//   Six register stages: products of quaternion parts, matrix entries,
//   matrix-by-vector products, two partial sums, final sum, round/saturate.
//   A beat is registered through every stage in order before out_valid rises;
//   while the receiver keeps out_ready high, one beat can enter every cycle,
//   so throughput is one rotation per clock.
// Reset and stall
//   rst clears all stage valid bits; no result is pending after reset.
//   When the receiver holds out_ready low, each stage keeps its beat and
//   bubbles ahead of it close up; in_ready drops only once every stage holds
//   a beat, so nothing is lost or repeated.
module vector_rotate_by_quaternion #(
  parameter int QUAT_FRAC_BITS = vrq_pkg::QUAT_FRAC_BITS_DEF,
  parameter int VEC_WIDTH      = vrq_pkg::VEC_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vrq_pkg::quat_t        quat_w,
  input  vrq_pkg::quat_t        quat_x,
  input  vrq_pkg::quat_t        quat_y,
  input  vrq_pkg::quat_t        quat_z,
  input  logic signed [vrq_pkg::VEC_IN_W-1:0] vec_x,
  input  logic signed [vrq_pkg::VEC_IN_W-1:0] vec_y,
  input  logic signed [vrq_pkg::VEC_IN_W-1:0] vec_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vrq_pkg::res_t         out_x,
  output vrq_pkg::res_t         out_y,
  output vrq_pkg::res_t         out_z,
  output logic                  saturated
);

  import vrq_pkg::*;

  localparam int NSTAGE = 6;

  // Stage valid bits and per-stage ready; rdy[NSTAGE+1] is the receiver
  logic [NSTAGE:1]   vld;
  logic [NSTAGE+1:1] rdy;

  always_comb begin
    rdy[NSTAGE+1] = out_ready;
    for (int k = NSTAGE; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  // Advance a beat into stage k whenever stage k is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= in_valid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = vld[NSTAGE];

  // Vector extension: narrow widths sign-extend from bit VEC_WIDTH-1; wider
  // widths see zero upper bits, so the port value is zero-extended
  vext_t vx, vy, vz;

  generate
    if (VEC_WIDTH > VEC_IN_W) begin : g_vec_wide
      assign vx = signed'({1'b0, vec_x});
      assign vy = signed'({1'b0, vec_y});
      assign vz = signed'({1'b0, vec_z});
    end else begin : g_vec_narrow
      assign vx = VEXT_W'(signed'(vec_x[VEC_WIDTH-1:0]));
      assign vy = VEXT_W'(signed'(vec_y[VEC_WIDTH-1:0]));
      assign vz = VEXT_W'(signed'(vec_z[VEC_WIDTH-1:0]));
    end
  endgenerate

  // Stage 1: all pairwise products of the quaternion parts
  pp_t   p_ww, p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  vext_t v1_x, v1_y, v1_z;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p_ww <= quat_w * quat_w;
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
      p_xy <= quat_x * quat_y;
      p_xz <= quat_x * quat_z;
      p_yz <= quat_y * quat_z;
      p_wx <= quat_w * quat_x;
      p_wy <= quat_w * quat_y;
      p_wz <= quat_w * quat_z;
      v1_x <= vx;
      v1_y <= vy;
      v1_z <= vz;
    end
  end

  // Stage 2: entries of the unnormalized rotation matrix
  coef_t e_ww, e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
  coef_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  vext_t v2_x, v2_y, v2_z;

  assign e_ww = COEF_W'(p_ww);
  assign e_xx = COEF_W'(p_xx);
  assign e_yy = COEF_W'(p_yy);
  assign e_zz = COEF_W'(p_zz);
  assign e_xy = COEF_W'(p_xy);
  assign e_xz = COEF_W'(p_xz);
  assign e_yz = COEF_W'(p_yz);
  assign e_wx = COEF_W'(p_wx);
  assign e_wy = COEF_W'(p_wy);
  assign e_wz = COEF_W'(p_wz);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      r00  <= e_ww + e_xx - e_yy - e_zz;
      r01  <= (e_xy - e_wz) <<< 1;
      r02  <= (e_xz + e_wy) <<< 1;
      r10  <= (e_xy + e_wz) <<< 1;
      r11  <= e_ww - e_xx + e_yy - e_zz;
      r12  <= (e_yz - e_wx) <<< 1;
      r20  <= (e_xz - e_wy) <<< 1;
      r21  <= (e_yz + e_wx) <<< 1;
      r22  <= e_ww - e_xx - e_yy + e_zz;
      v2_x <= v1_x;
      v2_y <= v1_y;
      v2_z <= v1_z;
    end
  end

  // Stages 3 to 6: one row unit per output component
  stage_en_t en;
  logic      sat_x, sat_y, sat_z;

  assign en.s3 = rdy[3];
  assign en.s4 = rdy[4];
  assign en.s5 = rdy[5];
  assign en.s6 = rdy[6];

  vrq_row #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_row_x (
    .clk (clk), .en (en),
    .c0  (r00), .c1 (r01), .c2 (r02),
    .v0  (v2_x), .v1 (v2_y), .v2 (v2_z),
    .res (out_x), .sat (sat_x)
  );

  vrq_row #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_row_y (
    .clk (clk), .en (en),
    .c0  (r10), .c1 (r11), .c2 (r12),
    .v0  (v2_x), .v1 (v2_y), .v2 (v2_z),
    .res (out_y), .sat (sat_y)
  );

  vrq_row #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_row_z (
    .clk (clk), .en (en),
    .c0  (r20), .c1 (r21), .c2 (r22),
    .v0  (v2_x), .v1 (v2_y), .v2 (v2_z),
    .res (out_z), .sat (sat_z)
  );

  // Flag the beat if any component hit a bound
  assign saturated = sat_x | sat_y | sat_z;

endmodule
